[rtl/teea_pkg.sv]
// shared types and constants for the texture edge expansion addresser
package teea_pkg;

	localparam int MAX_SIZE_LOG2_DEF = 10;

	// mask exponent register width and the span needed for 2^(m+1)-1
	localparam int MASK_W = 4;
	localparam int MASK_SPAN_W = (2 ** MASK_W) + 1;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_AXIS_IS_T    = 3'd0,
		REG_LOAD_SIZE    = 3'd1,
		REG_CREATE_SIZE  = 3'd2,
		REG_CREATED_SIZE = 3'd3,
		REG_MASK_BITS    = 3'd4,
		REG_MIRROR_EN    = 3'd5,
		REG_CLAMP_EN     = 3'd6
	} cfg_reg_t;

	// expansion mode decoded from the configuration registers
	typedef struct packed {
		logic axis_t;
		logic mirror;
		logic load_lt_alloc;
		logic clamp_only;
		logic full_period;
		logic partial;
		logic short_tex;
	} mode_t;

endpackage

[rtl/teea_cfg.sv]
// configuration registers and mode decode for the edge expansion addresser
module teea_cfg #(
	parameter int MAX_SIZE_LOG2 = teea_pkg::MAX_SIZE_LOG2_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [teea_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [MAX_SIZE_LOG2:0]             cfg_data,
	output teea_pkg::mode_t                    mode,
	output logic [MAX_SIZE_LOG2:0]             load_size,
	output logic [MAX_SIZE_LOG2:0]             created_size,
	output logic [MAX_SIZE_LOG2:0]             limit,
	output logic [MAX_SIZE_LOG2:0]             wrap_size,
	output logic [teea_pkg::MASK_SPAN_W-1:0]   mask_lo,
	output logic [teea_pkg::MASK_SPAN_W-1:0]   mask_hi
);
	import teea_pkg::*;

	localparam int SW = MAX_SIZE_LOG2 + 1;

	logic            axis_is_t_q;
	logic [SW-1:0]   load_size_q;
	logic [SW-1:0]   create_size_q;
	logic [SW-1:0]   created_size_q;
	logic [MASK_W-1:0] mask_bits_q;
	logic            mirror_en_q;
	logic            clamp_en_q;
	logic [MASK_SPAN_W-1:0] period;
	logic [MASK_SPAN_W-1:0] load_ext;
	logic [MASK_SPAN_W-1:0] create_ext;
	logic [MASK_SPAN_W-1:0] created_ext;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_is_t_q    <= 1'b0;
			load_size_q    <= '0;
			create_size_q  <= '0;
			created_size_q <= '0;
			mask_bits_q    <= '0;
			mirror_en_q    <= 1'b0;
			clamp_en_q     <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_AXIS_IS_T:    axis_is_t_q    <= cfg_data[0];
				REG_LOAD_SIZE:    load_size_q    <= cfg_data;
				REG_CREATE_SIZE:  create_size_q  <= cfg_data;
				REG_CREATED_SIZE: created_size_q <= cfg_data;
				REG_MASK_BITS:    mask_bits_q    <= cfg_data[MASK_W-1:0];
				REG_MIRROR_EN:    mirror_en_q    <= cfg_data[0];
				REG_CLAMP_EN:     clamp_en_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// mask_hi = 2^(m+1)-1, mask_lo = 2^m-1
	assign mask_hi = {MASK_SPAN_W{1'b1}} >> (MASK_SPAN_W - 1 - int'(mask_bits_q));
	assign mask_lo = mask_hi >> 1;
	assign period  = mask_lo + MASK_SPAN_W'(1);

	assign load_ext    = MASK_SPAN_W'(load_size_q);
	assign create_ext  = MASK_SPAN_W'(create_size_q);
	assign created_ext = MASK_SPAN_W'(created_size_q);

	assign load_size    = load_size_q;
	assign created_size = created_size_q;
	assign limit        = clamp_en_q ? create_size_q : created_size_q;

	always_comb begin
		mode.axis_t        = axis_is_t_q;
		mode.mirror        = mirror_en_q;
		mode.load_lt_alloc = load_size_q < created_size_q;
		mode.clamp_only    = mask_bits_q == '0;
		mode.full_period   = load_ext == period;
		mode.partial       = (load_size_q < create_size_q) && (create_ext == period)
			&& (created_ext == period);
		mode.short_tex     = (create_ext < period) && (load_size_q <= create_size_q);
	end

	// wrap end point: the limit when a full period is loaded, else the allocation
	assign wrap_size = mode.full_period ? limit : created_size_q;

endmodule

[rtl/texture_edge_expand_addresser_core.sv]
// Edge expansion addresser: for each destination coordinate along S or T it tells whether
// expansion writes that texel and which coordinate it is copied from. One request is taken
// every clock while dest_stall is low. Three register stages (input capture, range compares,
// source select) lie between an accepted request and its result. Stalls hold each stage and
// bubbles are squeezed out. Configuration is written through the cfg port, which is always
// ready, and must only change while no request is in flight.
module texture_edge_expand_addresser_core #(
	parameter int MAX_SIZE_LOG2 = teea_pkg::MAX_SIZE_LOG2_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [teea_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [MAX_SIZE_LOG2:0]         cfg_data,
	input  logic                           dest_valid,
	output logic                           dest_stall,
	input  logic [MAX_SIZE_LOG2-1:0]       dest_coord,
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic                           write_en,
	output logic [MAX_SIZE_LOG2-1:0]       source_coord
);
	import teea_pkg::*;

	localparam int CW = MAX_SIZE_LOG2;
	localparam int SW = MAX_SIZE_LOG2 + 1;

	mode_t                  mode;
	logic [SW-1:0]          load_size;
	logic [SW-1:0]          created_size;
	logic [SW-1:0]          limit;
	logic [SW-1:0]          wrap_size;
	logic [MASK_SPAN_W-1:0] mask_lo;
	logic [MASK_SPAN_W-1:0] mask_hi;

	teea_cfg #(
		.MAX_SIZE_LOG2(MAX_SIZE_LOG2)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mode        (mode),
		.load_size   (load_size),
		.created_size(created_size),
		.limit       (limit),
		.wrap_size   (wrap_size),
		.mask_lo     (mask_lo),
		.mask_hi     (mask_hi)
	);

	// stage handshake
	logic valid_s1, valid_s2, valid_s3;
	logic ready_1, ready_2, ready_3;

	assign ready_3    = !valid_s3 || !result_stall;
	assign ready_2    = !valid_s2 || ready_3;
	assign ready_1    = !valid_s1 || ready_2;
	assign dest_stall = !ready_1;

	// stage 1: capture coordinate
	logic [CW-1:0] x_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_1) begin
			valid_s1 <= dest_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_1 && dest_valid) begin
			x_s1 <= dest_coord;
		end
	end

	// stage 2: range compares and masked coordinates
	logic [SW-1:0]          x_ext;
	logic [MASK_SPAN_W-1:0] x_span;
	logic [CW-1:0]          xlo_c;
	logic [CW-1:0]          xhi_c;
	logic [CW-1:0]          x_s2;
	logic [CW-1:0]          xlo_s2;
	logic [CW-1:0]          xhi_s2;
	logic                   win_a_s2;
	logic                   win_b_s2;
	logic                   win_k_s2;
	logic                   mir_lo_s2;
	logic                   wrap_lo_s2;
	logic                   wrap_hi_s2;

	assign x_ext  = SW'(x_s1);
	assign x_span = MASK_SPAN_W'(x_s1);
	assign xlo_c  = x_s1 & mask_lo[CW-1:0];
	assign xhi_c  = x_s1 & mask_hi[CW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_2 && valid_s1) begin
			x_s2       <= x_s1;
			xlo_s2     <= xlo_c;
			xhi_s2     <= xhi_c;
			win_a_s2   <= (x_ext >= load_size) && (x_ext < limit);
			win_b_s2   <= (limit < created_size) && (limit != '0) && (x_ext >= limit)
				&& (x_ext < created_size);
			win_k_s2   <= (load_size != '0) && (x_ext >= load_size) && (x_ext < created_size);
			mir_lo_s2  <= MASK_SPAN_W'(xhi_c) <= mask_lo;
			wrap_lo_s2 <= SW'(xlo_c) < load_size;
			wrap_hi_s2 <= x_span > mask_lo;
		end
	end

	// stage 3: source candidates and final selection
	logic [CW-1:0] mirror_src;
	logic [CW-1:0] wrap_src;
	logic [CW-1:0] load_last;
	logic [CW-1:0] limit_last;
	logic          we_c;
	logic [CW-1:0] src_c;
	logic          we_s3;
	logic [CW-1:0] src_s3;
	logic          partial_in;

	assign mirror_src = mir_lo_s2 ? xlo_s2 : (mask_hi[CW-1:0] - xhi_s2);
	assign load_last  = load_size[CW-1:0] - CW'(1);
	assign limit_last = limit[CW-1:0] - CW'(1);

	// axis specific wrap rules
	always_comb begin
		if (mode.axis_t) begin
			wrap_src = wrap_hi_s2 ? xlo_s2 : (x_s2 - load_size[CW-1:0]);
		end else begin
			wrap_src = wrap_lo_s2 ? xlo_s2 : (wrap_size[CW-1:0] - xlo_s2);
		end
	end

	// the clamp-only window needs a nonzero load, the partial one does not
	assign partial_in = (SW'(x_s2) >= load_size) && (SW'(x_s2) < created_size);

	always_comb begin
		we_c  = 1'b0;
		src_c = '0;
		if (mode.load_lt_alloc) begin
			priority if (mode.clamp_only) begin
				if (win_k_s2) begin
					we_c  = 1'b1;
					src_c = load_last;
				end
			end else if (mode.full_period) begin
				if (win_a_s2) begin
					we_c  = 1'b1;
					src_c = mode.mirror ? mirror_src : wrap_src;
				end
				if (win_b_s2) begin
					we_c  = 1'b1;
					src_c = limit_last;
				end
			end else if (mode.partial) begin
				if (partial_in) begin
					we_c  = 1'b1;
					src_c = wrap_src;
				end
			end else if (mode.short_tex) begin
				if (win_k_s2) begin
					we_c  = 1'b1;
					src_c = load_last;
				end
			end else begin
				we_c = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_3 && valid_s2) begin
			we_s3  <= we_c;
			src_s3 <= src_c;
		end
	end

	assign result_valid = valid_s3;
	assign write_en     = we_s3;
	assign source_coord = src_s3;

`ifndef SYNTHESIS
	// a result without a write carries source zero
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !write_en |-> source_coord == '0)
		else $error("source nonzero without write");

	// nothing is written when the load already covers the allocation
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && write_en |-> mode.load_lt_alloc)
		else $error("write with load not below allocation");

	// an accepted request shows up in stage one
	assert property (@(posedge clk) disable iff (!arst_n)
		dest_valid && !dest_stall |=> valid_s1)
		else $error("accepted request lost at stage one");

	// a held middle stage keeps its coordinate
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_3 |=> valid_s2 && $stable(x_s2))
		else $error("stage two changed while held");
`endif

endmodule
